// ----- rtl/matrix3_adjugate_determinant_macros.svh -----
// ---------------------------------------------------------------------------
// matrix3 adjugate determinant assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef MATRIX3_ADJUGATE_DETERMINANT_MACROS_SVH
`define MATRIX3_ADJUGATE_DETERMINANT_MACROS_SVH

// same-cycle implication
`define MAD_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define MAD_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ----- rtl/mad_pkg.sv -----
// ---------------------------------------------------------------------------
// mad_pkg
// widths, matrix type, cofactor operand tables and back-end states
// ---------------------------------------------------------------------------
package mad_pkg;

    localparam int IN_BITS     = 16;
    localparam int ELEM_BITS   = 16;
    localparam int ADJ_BITS    = 2 * ELEM_BITS + 1;
    localparam int DET_BITS    = 3 * ELEM_BITS + 1;
    localparam int N_ENTRIES   = 9;
    localparam int IDX_BITS    = $clog2(N_ENTRIES);
    localparam int MINOR_STEPS = 2 * N_ENTRIES;
    localparam int LAST_STEP   = MINOR_STEPS + 2;
    localparam int STEP_BITS   = $clog2(LAST_STEP + 1);
    localparam int FIFO_DEPTH  = 2;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    localparam logic [IDX_BITS-1:0]  LAST_POS   = IDX_BITS'(N_ENTRIES - 1);
    localparam logic [STEP_BITS-1:0] STEP_DET   = STEP_BITS'(MINOR_STEPS);
    localparam logic [STEP_BITS-1:0] STEP_LAST  = STEP_BITS'(LAST_STEP);

    typedef logic [N_ENTRIES-1:0][ELEM_BITS-1:0] matrix_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ACC,
        BK_EMIT
    } back_state_t;

    // first operand position: even steps give p, odd steps give q of a minor,
    // the last three steps walk the first row for the determinant
    function automatic logic [IDX_BITS-1:0] opa_pos(input logic [STEP_BITS-1:0] step);
        logic [IDX_BITS-1:0] pos;
        case (step)
            STEP_BITS'(0):  pos = IDX_BITS'(4);
            STEP_BITS'(1):  pos = IDX_BITS'(5);
            STEP_BITS'(2):  pos = IDX_BITS'(1);
            STEP_BITS'(3):  pos = IDX_BITS'(2);
            STEP_BITS'(4):  pos = IDX_BITS'(1);
            STEP_BITS'(5):  pos = IDX_BITS'(2);
            STEP_BITS'(6):  pos = IDX_BITS'(3);
            STEP_BITS'(7):  pos = IDX_BITS'(5);
            STEP_BITS'(8):  pos = IDX_BITS'(0);
            STEP_BITS'(9):  pos = IDX_BITS'(2);
            STEP_BITS'(10): pos = IDX_BITS'(0);
            STEP_BITS'(11): pos = IDX_BITS'(2);
            STEP_BITS'(12): pos = IDX_BITS'(3);
            STEP_BITS'(13): pos = IDX_BITS'(4);
            STEP_BITS'(14): pos = IDX_BITS'(0);
            STEP_BITS'(15): pos = IDX_BITS'(1);
            STEP_BITS'(16): pos = IDX_BITS'(0);
            STEP_BITS'(17): pos = IDX_BITS'(1);
            STEP_BITS'(18): pos = IDX_BITS'(0);
            STEP_BITS'(19): pos = IDX_BITS'(1);
            STEP_BITS'(20): pos = IDX_BITS'(2);
            default:        pos = IDX_BITS'(0);
        endcase
        return pos;
    endfunction

    function automatic logic [IDX_BITS-1:0] opb_pos(input logic [STEP_BITS-1:0] step);
        logic [IDX_BITS-1:0] pos;
        case (step)
            STEP_BITS'(0):  pos = IDX_BITS'(8);
            STEP_BITS'(1):  pos = IDX_BITS'(7);
            STEP_BITS'(2):  pos = IDX_BITS'(8);
            STEP_BITS'(3):  pos = IDX_BITS'(7);
            STEP_BITS'(4):  pos = IDX_BITS'(5);
            STEP_BITS'(5):  pos = IDX_BITS'(4);
            STEP_BITS'(6):  pos = IDX_BITS'(8);
            STEP_BITS'(7):  pos = IDX_BITS'(6);
            STEP_BITS'(8):  pos = IDX_BITS'(8);
            STEP_BITS'(9):  pos = IDX_BITS'(6);
            STEP_BITS'(10): pos = IDX_BITS'(5);
            STEP_BITS'(11): pos = IDX_BITS'(3);
            STEP_BITS'(12): pos = IDX_BITS'(7);
            STEP_BITS'(13): pos = IDX_BITS'(6);
            STEP_BITS'(14): pos = IDX_BITS'(7);
            STEP_BITS'(15): pos = IDX_BITS'(6);
            STEP_BITS'(16): pos = IDX_BITS'(4);
            STEP_BITS'(17): pos = IDX_BITS'(3);
            default:        pos = IDX_BITS'(0);
        endcase
        return pos;
    endfunction

endpackage

// ----- rtl/mad_front.sv -----
// ---------------------------------------------------------------------------
// mad_front
// loads elements row-major and hands each complete matrix to the queue
// ---------------------------------------------------------------------------
module mad_front
    import mad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                elem_valid,
    output logic                elem_ready,
    input  logic [IN_BITS-1:0]  element,
    input  logic                first,
    output logic                push_valid,
    input  logic                push_ready,
    output matrix_t             push_data
);

    matrix_t             mat_reg;
    logic [IDX_BITS-1:0] count_reg;
    logic [IDX_BITS-1:0] count_next;
    logic [IDX_BITS-1:0] pos;
    logic                accept;

    assign pos        = first ? '0 : count_reg;
    assign elem_ready = push_ready || (pos != LAST_POS);
    assign push_valid = elem_valid && (pos == LAST_POS);
    assign accept     = elem_valid && elem_ready;

    always_comb
    begin
        push_data = mat_reg;
        push_data[pos] = element[ELEM_BITS-1:0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = (pos == LAST_POS) ? '0 : pos + IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mat_reg[pos] <= element[ELEM_BITS-1:0];
        end
    end

endmodule

// ----- rtl/mad_fifo.sv -----
// ---------------------------------------------------------------------------
// mad_fifo
// short matrix queue between the loader and the cofactor engine
// ---------------------------------------------------------------------------
module mad_fifo
    import mad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  matrix_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output matrix_t pop_data
);

    matrix_t             mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_BITS'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/mad_back.sv -----
// ---------------------------------------------------------------------------
// mad_back
// cofactors and determinant on one shared multiplier, then emits nine entries
// ---------------------------------------------------------------------------
module mad_back
    import mad_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  matrix_t                    pop_data,
    output logic                       adj_valid,
    input  logic                       adj_ready,
    output logic signed [ADJ_BITS-1:0] adj_entry,
    output logic [IDX_BITS-1:0]        entry_index,
    output logic signed [DET_BITS-1:0] det_value,
    output logic                       last
);

    `include "matrix3_adjugate_determinant_macros.svh"

    back_state_t                state_reg;
    back_state_t                state_next;
    matrix_t                    mat_reg;
    logic [STEP_BITS-1:0]       step_reg;
    logic [STEP_BITS-1:0]       pstep_reg;
    logic                       pvalid_reg;
    logic signed [DET_BITS-1:0] prod_reg;
    logic signed [DET_BITS-1:0] prod_next;
    logic signed [ADJ_BITS-1:0] phold_reg;
    logic signed [ADJ_BITS-1:0] adj_reg [N_ENTRIES];
    logic signed [DET_BITS-1:0] det_reg;
    logic [IDX_BITS-1:0]        out_cnt_reg;
    logic                       out_valid_reg;
    logic signed [ADJ_BITS-1:0] out_adj_reg;
    logic [IDX_BITS-1:0]        out_idx_reg;
    logic signed [DET_BITS-1:0] out_det_reg;
    logic                       out_last_reg;

    logic                       start;
    logic                       mul_en;
    logic                       emit_en;
    logic signed [ELEM_BITS-1:0] op_a;
    logic signed [ELEM_BITS-1:0] elem_b;
    logic signed [ADJ_BITS-1:0]  op_b;
    logic signed [ADJ_BITS-1:0]  prod_lo;
    logic signed [ADJ_BITS-1:0]  minor;
    logic signed [ADJ_BITS-1:0]  cofactor;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (pop_valid) state_next = BK_MUL;
            BK_MUL:  if (step_reg == STEP_LAST) state_next = BK_ACC;
            BK_ACC:  state_next = BK_EMIT;
            BK_EMIT: if (emit_en && out_cnt_reg == LAST_POS) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop_ready = 1'b0;
        mul_en    = 1'b0;
        emit_en   = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop_ready = 1'b1;
            BK_MUL:  mul_en = 1'b1;
            BK_ACC:  ;
            BK_EMIT: emit_en = !out_valid_reg || adj_ready;
            default: ;
        endcase
    end

    assign start = pop_valid && pop_ready;

    // operand selection and the shared multiplier
    always_comb
    begin
        op_a   = mat_reg[opa_pos(step_reg)];
        elem_b = mat_reg[opb_pos(step_reg)];
        case (step_reg)
            STEP_DET:                    op_b = adj_reg[0];
            STEP_DET + STEP_BITS'(1):    op_b = adj_reg[3];
            STEP_LAST:                   op_b = adj_reg[6];
            default:                     op_b = ADJ_BITS'(elem_b);
        endcase
        prod_next = op_a * op_b;
    end

    assign prod_lo  = prod_reg[ADJ_BITS-1:0];
    assign minor    = phold_reg - prod_lo;
    assign cofactor = pstep_reg[1] ? -minor : minor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            pstep_reg     <= '0;
            pvalid_reg    <= 1'b0;
            out_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pvalid_reg <= mul_en;
            pstep_reg  <= step_reg;
            if (start)
            begin
                step_reg <= '0;
            end
            else if (mul_en)
            begin
                step_reg <= step_reg + STEP_BITS'(1);
            end
            if (state_reg == BK_ACC)
            begin
                out_cnt_reg <= '0;
            end
            else if (emit_en)
            begin
                out_cnt_reg <= out_cnt_reg + IDX_BITS'(1);
            end
            if (emit_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (adj_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mat_reg <= pop_data;
        end
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (start)
        begin
            det_reg <= '0;
        end
        else if (pvalid_reg)
        begin
            if (pstep_reg < STEP_DET)
            begin
                if (!pstep_reg[0])
                begin
                    phold_reg <= prod_lo;
                end
                else
                begin
                    adj_reg[pstep_reg[STEP_BITS-1:1]] <= cofactor;
                end
            end
            else
            begin
                det_reg <= det_reg + prod_reg;
            end
        end
        if (emit_en)
        begin
            out_adj_reg  <= adj_reg[out_cnt_reg];
            out_idx_reg  <= out_cnt_reg;
            out_det_reg  <= det_reg;
            out_last_reg <= (out_cnt_reg == LAST_POS);
        end
    end

    assign adj_valid   = out_valid_reg;
    assign adj_entry   = out_adj_reg;
    assign entry_index = out_idx_reg;
    assign det_value   = out_det_reg;
    assign last        = out_last_reg;

    `MAD_ASSERT_NOW(a_step_range, state_reg == BK_MUL, step_reg <= STEP_LAST)
    `MAD_ASSERT_NOW(a_emit_range, state_reg == BK_EMIT, out_cnt_reg <= LAST_POS)
    `MAD_ASSERT_NEXT(a_emit_done, emit_en && out_cnt_reg == LAST_POS, state_reg == BK_IDLE)
    `MAD_ASSERT_NOW(a_no_pop_busy, state_reg != BK_IDLE, !pop_ready)

endmodule

// ----- rtl/matrix3_adjugate_determinant.sv -----
// after the ninth element is taken, the matrix passes the queue, the multiply steps and the
// accumulate state, then the first adjugate entry is registered; the other eight follow one
// per cycle when the output is not stalled. 21 products per matrix share the single multiplier.
// a new matrix is taken only after all nine issue, while a two-deep queue lets loading run ahead
// reset: load count, queue and engine control clear, a partial load is dropped
// ---------------------------------------------------------------------------
// matrix3_adjugate_determinant
// 3x3 adjugate and determinant unit, one element per request, nine results per matrix
// ---------------------------------------------------------------------------
module matrix3_adjugate_determinant
    import mad_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       elem_valid,
    output logic                       elem_ready,
    input  logic signed [IN_BITS-1:0]  element,
    input  logic                       first,
    output logic                       adj_valid,
    input  logic                       adj_ready,
    output logic signed [ADJ_BITS-1:0] adj_entry,
    output logic [IDX_BITS-1:0]        entry_index,
    output logic signed [DET_BITS-1:0] det_value,
    output logic                       last
);

    logic    push_valid;
    logic    push_ready;
    matrix_t push_data;
    logic    pop_valid;
    logic    pop_ready;
    matrix_t pop_data;

    mad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .element    (element),
        .first      (first),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mad_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mad_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .adj_valid   (adj_valid),
        .adj_ready   (adj_ready),
        .adj_entry   (adj_entry),
        .entry_index (entry_index),
        .det_value   (det_value),
        .last        (last)
    );

endmodule
